>>> hdl/tmb_pkg.sv
// Shared types and constants for the task message box.
// No dependencies; the controller, datapath and core files refer to it by scoped names.
`timescale 1ns / 1ps
package tmb_pkg;
	localparam int Depth = 16;
	localparam int SlotW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam int Words = 8;
	localparam int PayW = Words * 64;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_PULL = 1'b1;

	localparam logic [1:0] ST_PUSHED = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FOUND = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic kind;
		logic [7:0] task_id;
		logic [63:0] msg_word0;
		logic [63:0] msg_word1;
		logic [63:0] msg_word2;
		logic [63:0] msg_word3;
		logic [63:0] msg_word4;
		logic [63:0] msg_word5;
		logic [63:0] msg_word6;
		logic [63:0] msg_word7;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] event_task;
		logic [CntW-1:0] occupancy;
		logic [63:0] out_word0;
		logic [63:0] out_word1;
		logic [63:0] out_word2;
		logic [63:0] out_word3;
		logic [63:0] out_word4;
		logic [63:0] out_word5;
		logic [63:0] out_word6;
		logic [63:0] out_word7;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;    // item taken this cycle, finish push or miss now
		logic finish;    // payload read back, deliver found result
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pull_hit;  // current item is a pull with a matching entry
	} dp_stat_t;
endpackage

>>> hdl/tmb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tmb_ram #(
	parameter int Width = 8,
	parameter int Entries = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Entries)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Entries)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Entries];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/tmb_ctrl.sv
// Controller for the task message box: sequences a pull that must read back a payload.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
module tmb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input tmb_pkg::dp_stat_t stat,
	output tmb_pkg::dp_cmd_t cmd,
	output logic busy
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;

	always_comb begin
		busy = (state_q != S_IDLE);
		cmd.accept = start && (state_q == S_IDLE);
		cmd.finish = (state_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && stat.pull_hit) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> hdl/tmb_dp.sv
// Datapath for the task message box: ordered tag cells, slot allocation, payload RAM.
// Depends on tmb_pkg and tmb_ram.
`timescale 1ns / 1ps
module tmb_dp (
	input logic clk,
	input logic arst_n,
	input tmb_pkg::item_t item,
	input tmb_pkg::dp_cmd_t cmd,
	output tmb_pkg::dp_stat_t stat,
	output tmb_pkg::result_t result,
	output logic strobe
);
	// Cells kept oldest first; each points at the RAM slot holding its payload.
	logic [7:0] cell_task_q [tmb_pkg::Depth];
	logic [tmb_pkg::SlotW-1:0] cell_ptr_q [tmb_pkg::Depth];
	logic [tmb_pkg::CntW-1:0] count_q;
	logic [tmb_pkg::Depth-1:0] used_q;

	logic full;
	logic [tmb_pkg::SlotW-1:0] free_slot;
	logic hit;
	logic [tmb_pkg::SlotW-1:0] hit_idx;
	logic [tmb_pkg::SlotW-1:0] hit_ptr;
	logic [tmb_pkg::SlotW-1:0] tail;
	logic do_push;
	logic do_pull;
	logic [tmb_pkg::PayW-1:0] wdata;
	logic [tmb_pkg::PayW-1:0] rdata;
	tmb_pkg::result_t result_d;

	always_comb begin
		full = (count_q == tmb_pkg::CntW'(tmb_pkg::Depth));
		tail = count_q[tmb_pkg::SlotW-1:0];
		free_slot = '0;
		for (int i = tmb_pkg::Depth - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = tmb_pkg::SlotW'(i);
			end
		end
		hit = 1'b0;
		hit_idx = '0;
		for (int i = tmb_pkg::Depth - 1; i >= 0; i--) begin
			if ((tmb_pkg::CntW'(i) < count_q) && (cell_task_q[i] == item.task_id)) begin
				hit = 1'b1;
				hit_idx = tmb_pkg::SlotW'(i);
			end
		end
		hit_ptr = cell_ptr_q[hit_idx];
		stat.pull_hit = (item.kind == tmb_pkg::KIND_PULL) && hit;
		do_push = cmd.accept && (item.kind == tmb_pkg::KIND_PUSH) && !full;
		do_pull = cmd.accept && stat.pull_hit;
		wdata = {item.msg_word7, item.msg_word6, item.msg_word5, item.msg_word4,
			item.msg_word3, item.msg_word2, item.msg_word1, item.msg_word0};
	end

	// Next result: a found pull delivers the payload read back from the RAM,
	// anything else is answered straight from the item and the count.
	always_comb begin
		result_d = '0;
		if (cmd.finish) begin
			result_d.status = tmb_pkg::ST_FOUND;
			result_d.occupancy = count_q;
			{result_d.out_word7, result_d.out_word6, result_d.out_word5,
				result_d.out_word4, result_d.out_word3, result_d.out_word2,
				result_d.out_word1, result_d.out_word0} = rdata;
		end else if (item.kind == tmb_pkg::KIND_PUSH) begin
			if (full) begin
				result_d.status = tmb_pkg::ST_FULL;
				result_d.occupancy = count_q;
			end else begin
				result_d.status = tmb_pkg::ST_PUSHED;
				result_d.event_task = item.task_id;
				result_d.occupancy = count_q + 1'b1;
			end
		end else begin
			result_d.status = tmb_pkg::ST_NONE;
			result_d.occupancy = count_q;
		end
	end

	tmb_ram #(
		.Width(tmb_pkg::PayW),
		.Entries(tmb_pkg::Depth)
	) u_payload (
		.clk(clk),
		.we(do_push),
		.waddr(free_slot),
		.wdata(wdata),
		.raddr(hit_ptr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= (cmd.accept && !stat.pull_hit) || cmd.finish;
			if (do_push) begin
				count_q <= count_q + 1'b1;
				used_q[free_slot] <= 1'b1;
			end else if (do_pull) begin
				count_q <= count_q - 1'b1;
				used_q[hit_ptr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cell_task_q[tail] <= item.task_id;
			cell_ptr_q[tail] <= free_slot;
		end else if (do_pull) begin
			for (int i = 0; i < tmb_pkg::Depth - 1; i++) begin
				if (tmb_pkg::SlotW'(i) >= hit_idx) begin
					cell_task_q[i] <= cell_task_q[i+1];
					cell_ptr_q[i] <= cell_ptr_q[i+1];
				end
			end
		end
		if (cmd.finish || cmd.accept) begin
			result <= result_d;
		end
	end
endmodule

>>> hdl/task_message_box_core.sv
// Task message box: up to 16 messages kept in arrival order, pulled by task number.
// A push or a missed pull gives its result in the cycle after the start beat;
// a found pull first reads its payload into the RAM's read register, then registers the result.
// Throughput: one beat a cycle for pushes and misses; a found pull holds busy while its payload is read.
// Reset (arst_n low) empties the box at once; the receiver cannot stall results.
// Depends on tmb_pkg, tmb_ctrl and tmb_dp.
`timescale 1ns / 1ps
module task_message_box_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input tmb_pkg::item_t item,
	output logic busy,
	output logic strobe,
	output tmb_pkg::result_t result
);
	// Commands from the controller and the hit status back from the datapath.
	tmb_pkg::dp_cmd_t cmd;
	tmb_pkg::dp_stat_t stat;

	// The controller only tracks whether a payload read is outstanding.
	tmb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	// The datapath holds the ordered tag cells, the free-slot map and the payload RAM.
	// A pull removes the oldest match by shifting later cells down one place; the
	// payloads themselves never move, so the RAM needs one write and one read port.
	tmb_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.stat(stat),
		.result(result),
		.strobe(strobe)
	);
endmodule
